@@ hw/rtl/iqr_pkg.sv @@
// shared constants and types for the iqr outlier test
package iqr_pkg;

	localparam int MAX_SAMPLES_DEF = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_FEW = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;

	localparam int MIN_SAMPLES = 4;

	typedef struct packed {
		logic ins;
		logic drain;
	} cell_ctl_t;

endpackage

@@ hw/rtl/iqr_outlier_test.sv @@
// Tukey fence outlier test over a streamed set of signed samples.
// Samples are taken one per cycle into a chain of MAX_SAMPLES sorting cells,
// each insertion finishing in the cycle the item is accepted. The item with
// tlast set also carries the test value; after it the chain shifts toward
// cell 0 to read out q1 (index floor(n/4)) and q3 (index floor(3n/4)),
// then the CALC state evaluates the fences 2*v < 5*q1 - 3*q3 or
// 2*v > 5*q3 - 3*q1 and loads the result register, waiting there while an
// earlier result is still held by the receiver.
// A set of fewer than four samples skips the readout and reports too_few.
// Samples arriving with the store full are dropped and the set reports
// dropped. tready is low from the last item until its result is loaded.
module iqr_outlier_test #(
	parameter int MAX_SAMPLES = iqr_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = iqr_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// sample, test_value
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// is_outlier, status
	output logic [7:0]                           m_tdata
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int FW    = SAMPLE_BITS + 4;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);
	localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(iqr_pkg::MIN_SAMPLES);

	typedef enum logic [1:0] {IDLE, DRAIN, CALC} state_t;

	state_t                          state_q;
	logic        [CNT_W-1:0]         count_q;
	logic        [CNT_W-1:0]         k_q;
	logic                            dropped_q;
	logic signed [SAMPLE_BITS-1:0]   tv_q;
	logic signed [SAMPLE_BITS-1:0]   q1_q;
	logic signed [SAMPLE_BITS-1:0]   q3_q;
	logic                            outlier_q;
	logic        [iqr_pkg::STATUS_W-1:0] status_q;

	logic                            accept;
	logic                            full;
	logic signed [SAMPLE_BITS-1:0]   sample;
	logic signed [SAMPLE_BITS-1:0]   test_value;
	logic        [CNT_W-1:0]         idx1;
	logic        [CNT_W+1:0]         three_n;
	logic        [CNT_W-1:0]         idx3;
	iqr_pkg::cell_ctl_t              ctl;
	logic                            gt_w  [MAX_SAMPLES];
	logic signed [SAMPLE_BITS-1:0]   val_w [MAX_SAMPLES];
	logic signed [FW-1:0]            q1_e, q3_e, v2, lo, hi;
	logic                            out_free;

	assign sample     = s_tdata[SAMPLE_BITS-1:0];
	assign test_value = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
	assign s_tready   = state_q == IDLE;
	assign accept     = s_tvalid && s_tready;
	assign full       = count_q == CNT_MAX;
	assign ctl.ins    = accept && !full;
	assign ctl.drain  = state_q == DRAIN;

	assign idx1    = CNT_W'(count_q >> 2);
	assign three_n = {count_q, 1'b0} + (CNT_W+2)'(count_q);
	assign idx3    = three_n[CNT_W+1:2];

	for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
		logic                          lgt;
		logic signed [SAMPLE_BITS-1:0] lval, rval;
		if (i == 0) begin : g_first
			assign lgt  = 1'b0;
			assign lval = '0;
		end else begin : g_mid
			assign lgt  = gt_w[i-1];
			assign lval = val_w[i-1];
		end
		if (i == MAX_SAMPLES - 1) begin : g_end
			assign rval = '0;
		end else begin : g_nxt
			assign rval = val_w[i+1];
		end
		iqr_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.CNT_W      (CNT_W),
			.IDX        (i)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.count    (count_q),
			.sample   (sample),
			.left_gt  (lgt),
			.left_val (lval),
			.right_val(rval),
			.gt       (gt_w[i]),
			.val      (val_w[i])
		);
	end

	assign q1_e     = FW'(q1_q);
	assign q3_e     = FW'(q3_q);
	assign v2       = FW'(tv_q) <<< 1;
	assign lo       = (q1_e <<< 2) + q1_e - ((q3_e <<< 1) + q3_e);
	assign hi       = (q3_e <<< 2) + q3_e - ((q1_e <<< 1) + q1_e);
	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk) begin
		if (accept && s_tlast) begin
			tv_q <= test_value;
		end
		if (state_q == DRAIN) begin
			if (k_q == idx1) begin
				q1_q <= val_w[0];
			end
			if (k_q == idx3) begin
				q3_q <= val_w[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			count_q   <= '0;
			dropped_q <= 1'b0;
			k_q       <= '0;
			m_tvalid  <= 1'b0;
			outlier_q <= 1'b0;
			status_q  <= iqr_pkg::ST_OK;
		end else begin
			if (m_tvalid && m_tready && state_q != CALC) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
						if (s_tlast) begin
							k_q <= '0;
							if ((full ? count_q : count_q + 1'b1) < CNT_MIN) begin
								state_q <= CALC;
							end else begin
								state_q <= DRAIN;
							end
						end
					end
				end
				DRAIN: begin
					if (k_q == idx3) begin
						state_q <= CALC;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				CALC: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						if (count_q < CNT_MIN) begin
							outlier_q <= 1'b0;
							status_q  <= iqr_pkg::ST_TOO_FEW;
						end else begin
							outlier_q <= (v2 < lo) || (v2 > hi);
							status_q  <= dropped_q ? iqr_pkg::ST_DROPPED : iqr_pkg::ST_OK;
						end
						count_q   <= '0;
						dropped_q <= 1'b0;
						state_q   <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign m_tdata = {5'd0, status_q, outlier_q};

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("sample count above capacity");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		dropped_q |-> count_q == CNT_MAX)
		else $error("drop flag set with store not full");

	a_too_few_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status_q == iqr_pkg::ST_TOO_FEW |-> !outlier_q)
		else $error("outlier flagged on too small a set");

	a_result_after_calc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == CALC)
		else $error("result loaded outside fence evaluation");
`endif

endmodule

@@ hw/rtl/iqr_cell.sv @@
// one cell of the insertion sorting chain
module iqr_cell #(
	parameter int SAMPLE_BITS = iqr_pkg::SAMPLE_BITS_DEF,
	parameter int CNT_W       = 7,
	parameter int IDX         = 0
) (
	input  logic                          clk,
	input  iqr_pkg::cell_ctl_t            ctl,
	input  logic        [CNT_W-1:0]       count,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          left_gt,
	input  logic signed [SAMPLE_BITS-1:0] left_val,
	input  logic signed [SAMPLE_BITS-1:0] right_val,
	output logic                          gt,
	output logic signed [SAMPLE_BITS-1:0] val
);

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

	logic signed [SAMPLE_BITS-1:0] val_q;
	logic                          occ;

	assign occ = MY_IDX < count;
	assign gt  = occ && (val_q > sample);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (left_gt) begin
				val_q <= left_val;
			end else if (gt || MY_IDX == count) begin
				val_q <= sample;
			end
		end else if (ctl.drain) begin
			val_q <= right_val;
		end
	end

endmodule

@@ tb/iqr_checker.sv @@
// checker for the iqr outlier test: predicts fence results and compares them
module iqr_checker #(
	parameter int MAX_SAMPLES = iqr_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = iqr_pkg::SAMPLE_BITS_DEF,
	parameter int IN_W = ((2*SAMPLE_BITS+7)/8)*8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            s_tready,
	// sample, test_value
	input  logic [IN_W-1:0] s_tdata,
	input  logic            s_tlast,
	input  logic            m_tvalid,
	input  logic            m_tready,
	// is_outlier, status
	input  logic [7:0]      m_tdata,
	output int              errors,
	output int              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic                         is_outlier;
		logic [iqr_pkg::STATUS_W-1:0] status;
	} verdict_t;

	sample_t  sorted_set[$];
	bit       set_dropped;
	verdict_t verdict_q[$];

	// equal values keep arrival order
	function automatic void insert_sample(sample_t s);
		int pos;
		if (sorted_set.size() >= MAX_SAMPLES) begin
			set_dropped = 1'b1;
			return;
		end
		pos = sorted_set.size();
		while (pos > 0 && sorted_set[pos-1] > s)
			pos--;
		sorted_set.insert(pos, s);
	endfunction

	function automatic verdict_t fence_verdict(sample_t v);
		verdict_t r;
		int       n;
		longint   q1, q3, iqr, v2;
		n = sorted_set.size();
		r.is_outlier = 1'b0;
		if (n < iqr_pkg::MIN_SAMPLES) begin
			r.status = iqr_pkg::ST_TOO_FEW;
		end else begin
			q1 = sorted_set[n/4];
			q3 = sorted_set[(3*n)/4];
			iqr = q3 - q1;
			v2 = 2 * longint'(v);
			r.is_outlier = (v2 < 2*q1 - 3*iqr) || (v2 > 2*q3 + 3*iqr);
			r.status = set_dropped ? iqr_pkg::ST_DROPPED : iqr_pkg::ST_OK;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t want;
		if (!arst_n) begin
			sorted_set.delete();
			set_dropped = 1'b0;
			verdict_q.delete();
			errors = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					$error("result with nothing expected: tdata %h", m_tdata);
					errors++;
				end else begin
					want = verdict_q.pop_front();
					if (m_tdata[0] !== want.is_outlier) begin
						$error("is_outlier: expected %0d, actual %0d", want.is_outlier,
							m_tdata[0]);
						errors++;
					end
					if (m_tdata[iqr_pkg::STATUS_W:1] !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status,
							m_tdata[iqr_pkg::STATUS_W:1]);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				insert_sample(s_tdata[SAMPLE_BITS-1:0]);
				if (s_tlast) begin
					verdict_q.push_back(fence_verdict(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
					sorted_set.delete();
					set_dropped = 1'b0;
				end
			end
		end
		pending = verdict_q.size();
	end

endmodule

@@ tb/testbench.sv @@
// top of the iqr outlier test bench: clock, reset, stimulus and verdict
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_SAMPLES  = iqr_pkg::MAX_SAMPLES_DEF;
	localparam int SAMPLE_BITS  = iqr_pkg::SAMPLE_BITS_DEF;
	localparam int IN_W         = ((2*SAMPLE_BITS+7)/8)*8;
	localparam int RANDOM_ITEMS = 800;
	localparam int IDLE_LIMIT   = 5000;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = MAX_SAMPLES + 16;
	localparam int SMAX         = 2**(SAMPLE_BITS-1) - 1;
	localparam int SMIN         = -(2**(SAMPLE_BITS-1));

	typedef logic [SAMPLE_BITS-1:0] word_t;
	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOP} rx_mode_t;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            s_tvalid;
	logic            s_tready;
	logic [IN_W-1:0] s_tdata;
	logic            s_tlast;
	logic            m_tvalid;
	logic            m_tready;
	logic [7:0]      m_tdata;
	int              errors;
	int              pending;
	int              idle_cycles = 0;
	bit              hold_req = 1'b0;
	int              sent = 0;
	int              burst_left = 0;

	always #5 clk = ~clk;

	iqr_outlier_test #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.SAMPLE_BITS(SAMPLE_BITS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	iqr_checker #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.SAMPLE_BITS(SAMPLE_BITS)
	) fence_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.errors  (errors),
		.pending (pending)
	);

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin : receiver
		rx_mode_t mode;
		int       span;
		int       phase;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				@(negedge clk) m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end
			mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(4, 80);
			phase = 0;
			repeat (span) begin
				@(negedge clk);
				case (mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
				RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:   m_tready <= ((phase % 5) < 2);
				endcase
				phase++;
			end
		end
	end

	task automatic send_item(word_t sample, word_t test_val, logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk) s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 20);
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'({test_val, sample});
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic word_t near(int center, int spread);
		int v;
		v = center + int'($urandom_range(0, 2*spread)) - spread;
		if (v > SMAX) v = SMAX;
		if (v < SMIN) v = SMIN;
		return word_t'(v);
	endfunction

	function automatic int set_size();
		int r;
		r = $urandom_range(0, 19);
		if (r < 15) return $urandom_range(1, 16);
		if (r < 18) return $urandom_range(17, 63);
		return $urandom_range(MAX_SAMPLES - 2, MAX_SAMPLES + 6);
	endfunction

	task automatic send_random_set(int n);
		int    center;
		int    spread;
		word_t test_val;
		center = SMIN + int'($urandom_range(0, SMAX - SMIN));
		spread = ($urandom_range(0, 4) == 0) ? SMAX : (1 << $urandom_range(0, 10));
		for (int i = 0; i < n - 1; i++)
			send_item(near(center, spread), word_t'($urandom), 1'b0);
		test_val = ($urandom_range(0, 2) == 0) ? word_t'($urandom) : near(center, 4*spread);
		send_item(near(center, spread), test_val, 1'b1);
		sent += n;
	endtask

	initial begin : stimulus
		bit held;
		bit drained;
		held = 1'b0;
		drained = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// too few samples
		send_item(word_t'(SMAX), word_t'(SMIN), 1'b1);
		send_item(word_t'(SMIN), word_t'(0), 1'b0);
		send_item(word_t'(0), word_t'(SMAX), 1'b0);
		send_item(word_t'(SMAX), word_t'(0), 1'b1);
		// full-range quartiles
		send_item(word_t'(SMIN), word_t'(0), 1'b0);
		send_item(word_t'(SMAX), word_t'(0), 1'b0);
		send_item(word_t'(SMIN), word_t'(0), 1'b0);
		send_item(word_t'(SMAX), word_t'(SMAX), 1'b1);
		// equal samples, zero spread
		repeat (3) send_item(word_t'(100), word_t'(SMIN), 1'b0);
		send_item(word_t'(100), word_t'(100), 1'b1);
		repeat (3) send_item(word_t'(100), word_t'(-1), 1'b0);
		send_item(word_t'(100), word_t'(101), 1'b1);
		repeat (3) send_item(word_t'(-5), word_t'(0), 1'b0);
		send_item(word_t'(-5), word_t'(-6), 1'b1);
		// descending arrival, low outlier
		send_item(word_t'(40), word_t'(0), 1'b0);
		send_item(word_t'(30), word_t'(0), 1'b0);
		send_item(word_t'(20), word_t'(0), 1'b0);
		send_item(word_t'(10), word_t'(0), 1'b0);
		send_item(word_t'(0), word_t'(SMIN), 1'b1);

		// store exactly full, then overflowing
		send_random_set(MAX_SAMPLES);
		send_random_set(MAX_SAMPLES + 1);
		send_random_set(MAX_SAMPLES + 6);

		while (sent < RANDOM_ITEMS) begin
			if (!held && sent >= 250) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			if (!drained && sent >= 500) begin
				@(negedge clk) s_tvalid <= 1'b0;
				wait (pending == 0);
				drained = 1'b1;
			end
			send_random_set(set_size());
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
